### src/pwc_pkg.sv
// pwc_pkg: shared types, codes and reset values for the pulse width capture block
// no dependencies; used by pwc_core and pwm_pulse_width_capture_top
package pwc_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_EDGE     = 2'd0;
   localparam logic [1:0] OP_OVERFLOW = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   // status codes of a result word
   localparam logic [1:0] STATUS_VALID       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT     = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHANNEL = 2'd2;

   // register indexes of the control port
   localparam logic [1:0] CSR_ACTIVE_CHANNELS = 2'd0;
   localparam logic [1:0] CSR_TIMER_RELOAD    = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_MAX_WIDTH       = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam int COUNT_W = 16;
   localparam int OVF_W   = 20;
   localparam int PROD_W  = OVF_W + COUNT_W;

   localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};

   // register reset values
   localparam logic [3:0]  ACTIVE_CHANNELS_RESET = 4'd8;
   localparam logic [15:0] TIMER_RELOAD_RESET    = 16'd65535;
   localparam logic [19:0] TIMEOUT_LIMIT_RESET   = 20'd100000;
   localparam logic [15:0] MAX_WIDTH_RESET       = 16'd3000;

   localparam int NUM_INPUTS_DEFAULT = 8;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  channel;
      logic [15:0] count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] width;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  active_channels;
      logic [15:0] timer_reload;
      logic [19:0] timeout_limit;
      logic [15:0] max_width;
   } cfg_type;

endpackage

### src/pwm_pulse_width_capture_top.sv
// pwm_pulse_width_capture_top: top level of the rc pwm pulse width capture block
// depends on pwc_pkg and pwc_core
//
// Measures pulse widths on up to NUM_INPUTS rc input channels. Each request word is a
// capture edge (timer count), a timer overflow (period count) or a read of one channel;
// only a read returns a response word, holding the last accepted width or a timeout /
// bad-channel status. Words pass through an input register, combinational channel
// update logic around a single 20x16 multiplier, and an output register, so the block
// takes one request word per cycle unless a read stalls the input. The output register
// decouples the sides: edges and overflows keep flowing while a read response waits;
// only a read that finds the response still stalled holds the input. The user must
// write registers through the csr port only while the block is idle; the block itself
// does not enforce this. csr_ready is always high.
module pwm_pulse_width_capture_top #(
   parameter int NUM_INPUTS = pwc_pkg::NUM_INPUTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pwc_pkg::req_type                 req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pwc_pkg::rsp_type                 rsp_data,
   // register write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pwc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pwc_pkg::CSR_DATA_W-1:0]   csr_data
);

   pwc_pkg::cfg_type cfg_ff;

   // input register
   logic             req_full_ff;
   pwc_pkg::req_type req_item_ff;

   // output register
   logic             rsp_full_ff;
   pwc_pkg::rsp_type rsp_item_ff;

   logic             is_read;
   logic             out_free;
   logic             proc;
   logic             take;
   pwc_pkg::rsp_type rd_data;

   // ---------------- control registers ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_channels <= pwc_pkg::ACTIVE_CHANNELS_RESET;
         cfg_ff.timer_reload    <= pwc_pkg::TIMER_RELOAD_RESET;
         cfg_ff.timeout_limit   <= pwc_pkg::TIMEOUT_LIMIT_RESET;
         cfg_ff.max_width       <= pwc_pkg::MAX_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pwc_pkg::CSR_ACTIVE_CHANNELS: cfg_ff.active_channels <= csr_data[3:0];
            pwc_pkg::CSR_TIMER_RELOAD:    cfg_ff.timer_reload    <= csr_data[15:0];
            pwc_pkg::CSR_TIMEOUT_LIMIT:   cfg_ff.timeout_limit   <= csr_data[19:0];
            pwc_pkg::CSR_MAX_WIDTH:       cfg_ff.max_width       <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- flow control ----------------
   // the word in the input register retires this cycle unless it is a read
   // and the output register is still holding an untaken response
   assign is_read   = req_item_ff.op == pwc_pkg::OP_READ;
   assign out_free  = !rsp_full_ff || !rsp_stall;
   assign proc      = req_full_ff && (!is_read || out_free);
   assign req_stall = req_full_ff && !proc;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
      end else if (take || proc) begin
         req_full_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_item_ff <= req_data;
      end
   end

   // ---------------- channel state and update ----------------
   pwc_core #(
      .NUM_INPUTS (NUM_INPUTS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .evt_en  (proc),
      .item    (req_item_ff),
      .cfg     (cfg_ff),
      .rd_data (rd_data)
   );

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_full_ff <= 1'b0;
      end else if (proc && is_read) begin
         rsp_full_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && is_read) begin
         rsp_item_ff <= rd_data;
      end
   end

   assign rsp_valid = rsp_full_ff;
   assign rsp_data  = rsp_item_ff;

endmodule

### src/pwc_core.sv
// pwc_core: per-channel capture state and the edge/overflow/read datapath
// depends on pwc_pkg
module pwc_core #(
   parameter int NUM_INPUTS = pwc_pkg::NUM_INPUTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             evt_en,
   input  pwc_pkg::req_type item,
   input  pwc_pkg::cfg_type cfg,
   output pwc_pkg::rsp_type rd_data
);

   localparam int IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

   logic                        awaiting_fall_ff [NUM_INPUTS];
   logic [pwc_pkg::COUNT_W-1:0] rise_count_ff    [NUM_INPUTS];
   logic [pwc_pkg::COUNT_W-1:0] pulse_width_ff   [NUM_INPUTS];
   logic                        timed_out_ff     [NUM_INPUTS];
   logic [pwc_pkg::OVF_W-1:0]   overflows_ff     [NUM_INPUTS];

   logic                        awaiting_fall_in;
   logic [pwc_pkg::COUNT_W-1:0] rise_count_in;
   logic [pwc_pkg::COUNT_W-1:0] pulse_width_in;
   logic                        timed_out_in;
   logic [pwc_pkg::OVF_W-1:0]   overflows_in;
   logic                        wr_en;

   logic [IDX_W-1:0]            idx;
   logic                        ch_in_range;
   logic                        ch_active;
   logic [pwc_pkg::OVF_W-1:0]   cur_ovf;
   logic [pwc_pkg::COUNT_W-1:0] cur_rise;
   logic [pwc_pkg::OVF_W-1:0]   ovf_inc;
   logic [pwc_pkg::OVF_W-1:0]   mul_a;
   logic [pwc_pkg::COUNT_W-1:0] mul_b;
   logic [pwc_pkg::PROD_W-1:0]  product;
   logic                        add_wrap;
   logic [pwc_pkg::PROD_W+1:0]  width_sum;
   logic                        width_ok;
   logic                        timeout_hit;

   assign idx         = item.channel[IDX_W-1:0];
   assign ch_in_range = item.channel < 8'(NUM_INPUTS);
   assign ch_active   = ch_in_range && (item.channel < {4'b0, cfg.active_channels});

   assign cur_ovf  = overflows_ff[idx];
   assign cur_rise = rise_count_ff[idx];
   assign ovf_inc  = (cur_ovf == pwc_pkg::OVF_MAX) ? cur_ovf : cur_ovf + 1'b1;

   // one multiplier shared by both event kinds
   assign mul_a   = (item.op == pwc_pkg::OP_OVERFLOW) ? ovf_inc : cur_ovf;
   assign mul_b   = (item.op == pwc_pkg::OP_OVERFLOW) ? item.count : cfg.timer_reload;
   assign product = pwc_pkg::PROD_W'(mul_a) * pwc_pkg::PROD_W'(mul_b);

   // fall minus rise, plus the wrapped periods, two extra bits for sign
   assign add_wrap  = (cur_ovf > 20'd1) || (item.count > cur_rise);
   assign width_sum = (pwc_pkg::PROD_W+2)'(item.count)
                    + (add_wrap ? (pwc_pkg::PROD_W+2)'(product) : '0)
                    - (pwc_pkg::PROD_W+2)'(cur_rise);
   assign width_ok  = !width_sum[pwc_pkg::PROD_W+1]
                    && (width_sum <= (pwc_pkg::PROD_W+2)'(cfg.max_width));

   assign timeout_hit = product >= pwc_pkg::PROD_W'(cfg.timeout_limit);

   always_comb begin
      awaiting_fall_in = awaiting_fall_ff[idx];
      rise_count_in    = cur_rise;
      pulse_width_in   = pulse_width_ff[idx];
      timed_out_in     = timed_out_ff[idx];
      overflows_in     = cur_ovf;
      wr_en            = 1'b0;
      case (item.op)
         pwc_pkg::OP_EDGE: begin
            wr_en = evt_en && ch_active;
            if (!awaiting_fall_ff[idx]) begin
               rise_count_in    = item.count;
               overflows_in     = '0;
               awaiting_fall_in = 1'b1;
            end else begin
               if (width_ok) begin
                  pulse_width_in = width_sum[pwc_pkg::COUNT_W-1:0];
                  timed_out_in   = 1'b0;
                  overflows_in   = '0;
               end
               awaiting_fall_in = 1'b0;
            end
         end
         pwc_pkg::OP_OVERFLOW: begin
            wr_en        = evt_en && ch_active;
            overflows_in = ovf_inc;
            if (timeout_hit) begin
               awaiting_fall_in = 1'b0;
               rise_count_in    = '0;
               timed_out_in     = 1'b1;
               overflows_in     = '0;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (!ch_in_range) begin
         rd_data.status = pwc_pkg::STATUS_BAD_CHANNEL;
         rd_data.width  = '0;
      end else if (timed_out_ff[idx]) begin
         rd_data.status = pwc_pkg::STATUS_TIMEOUT;
         rd_data.width  = '0;
      end else begin
         rd_data.status = pwc_pkg::STATUS_VALID;
         rd_data.width  = pulse_width_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            awaiting_fall_ff[i] <= 1'b0;
            rise_count_ff[i]    <= '0;
            pulse_width_ff[i]   <= '0;
            timed_out_ff[i]     <= 1'b1;
            overflows_ff[i]     <= '0;
         end
      end else if (wr_en) begin
         awaiting_fall_ff[idx] <= awaiting_fall_in;
         rise_count_ff[idx]    <= rise_count_in;
         pulse_width_ff[idx]   <= pulse_width_in;
         timed_out_ff[idx]     <= timed_out_in;
         overflows_ff[idx]     <= overflows_in;
      end
   end

endmodule

### verif/tb_pwm_pulse_width_capture_top.sv
// tb_pwm_pulse_width_capture_top: self-checking testbench for the pulse width capture block
// depends on pwc_pkg and pwm_pulse_width_capture_top; drives edge, overflow and read words
// under bursty traffic, predicts every read response and compares it field by field
`timescale 1ns / 1ps

module tb_pwm_pulse_width_capture_top;
   import pwc_pkg::*;

   localparam int NUM_CH = NUM_INPUTS_DEFAULT;

   // op code the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // a read answers through the input and output registers; a little margin on top
   localparam int SETTLE_CYCLES   = 8;
   // long receiver hold-off so the output fills and the input stalls
   localparam int HOLD_OFF_CYCLES = 400;
   // cycles with no handshake at all before the run is declared hung
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PHASE_WORDS     = 200;
   localparam int NUM_PHASES      = 9;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   // dut inputs, all known from time zero
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // capture state mirror, one entry per channel
   logic             fall_pending [NUM_CH];
   logic [15:0]      rise_at      [NUM_CH];
   logic [15:0]      held_width   [NUM_CH];
   logic             no_signal    [NUM_CH];
   logic [OVF_W-1:0] ovf_cnt      [NUM_CH];
   cfg_type          model_cfg;

   // words waiting to be sent, read responses waiting to come back
   req_type          words_to_send [$];
   rsp_type          widths_due    [$];

   // sender bookkeeping; word_offered is true while a popped word is on the bus
   logic             word_offered = 1'b0;
   int               burst_left   = 0;
   int               gap_left     = 0;

   // receiver bookkeeping
   logic             squeeze      = 1'b0;
   logic             squeeze_seen = 1'b0;
   int               hold_left    = 0;
   int               mode_left    = 0;
   stall_mode_type   stall_mode   = STALL_NONE;

   int               mismatches     = 0;
   int               edges_seen     = 0;
   int               overflows_seen = 0;
   int               reads_checked  = 0;
   int               planned_words  = 0;
   int               idle_cycles    = 0;

   pwm_pulse_width_capture_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // capture behavior mirror
   // ---------------------------------------------------------------------

   function automatic void clear_capture_state();
      for (int i = 0; i < NUM_CH; i++) begin
         fall_pending[i] = 1'b0;
         rise_at[i]      = '0;
         held_width[i]   = '0;
         no_signal[i]    = 1'b1;  // every channel starts out in timeout
         ovf_cnt[i]      = '0;
      end
      model_cfg.active_channels = ACTIVE_CHANNELS_RESET;
      model_cfg.timer_reload    = TIMER_RELOAD_RESET;
      model_cfg.timeout_limit   = TIMEOUT_LIMIT_RESET;
      model_cfg.max_width       = MAX_WIDTH_RESET;
   endfunction

   // update the mirror for one accepted word; a read queues the response it must give
   function automatic void apply_word(input req_type w);
      int      ch;
      bit      live;
      longint  span;
      rsp_type due;
      ch   = int'(w.channel);
      // events only land on wired channels that also exist in hardware
      live = (ch < int'(model_cfg.active_channels)) && (ch < NUM_CH);
      case (w.op)
         OP_EDGE: begin
            edges_seen++;
            if (live) begin
               if (!fall_pending[ch]) begin
                  // rising edge: remember the count, restart overflow tally
                  rise_at[ch]      = w.count;
                  ovf_cnt[ch]      = '0;
                  fall_pending[ch] = 1'b1;
               end else begin
                  // falling edge: exact width, reload added only past one overflow
                  // or when the fall count is above the rise count
                  span = longint'(w.count) - longint'(rise_at[ch]);
                  if (ovf_cnt[ch] > 1 || w.count > rise_at[ch])
                     span += longint'(ovf_cnt[ch]) * longint'(model_cfg.timer_reload);
                  if (span >= 0 && span <= longint'(model_cfg.max_width)) begin
                     held_width[ch] = span[15:0];
                     no_signal[ch]  = 1'b0;
                     ovf_cnt[ch]    = '0;
                  end
                  // a rejected width still rearms for the next rise
                  fall_pending[ch] = 1'b0;
               end
            end
         end
         OP_OVERFLOW: begin
            overflows_seen++;
            if (live) begin
               if (ovf_cnt[ch] != OVF_MAX)
                  ovf_cnt[ch] = ovf_cnt[ch] + 1'b1;
               if (longint'(ovf_cnt[ch]) * longint'(w.count) >=
                   longint'(model_cfg.timeout_limit)) begin
                  fall_pending[ch] = 1'b0;
                  rise_at[ch]      = '0;
                  no_signal[ch]    = 1'b1;
                  ovf_cnt[ch]      = '0;
               end
            end
         end
         OP_READ: begin
            // reads look only at the hardware channel count, not active_channels
            if (ch >= NUM_CH)
               due = '{status: STATUS_BAD_CHANNEL, width: 16'd0};
            else if (no_signal[ch])
               due = '{status: STATUS_TIMEOUT, width: 16'd0};
            else
               due = '{status: STATUS_VALID, width: held_width[ch]};
            widths_due.push_back(due);
         end
         default: ;  // unused op: no effect, no response
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // stimulus planning
   // ---------------------------------------------------------------------

   // queue one word; every word sent counts toward the plan
   function automatic void push_word(input logic [1:0] op, input int ch, input int cnt);
      req_type w;
      w.op      = op;
      w.channel = ch[7:0];
      w.count   = cnt[15:0];
      words_to_send.push_back(w);
      planned_words++;
   endfunction

   // mostly a live channel, sometimes any channel at all
   function automatic int aim_channel();
      int live;
      live = (int'(model_cfg.active_channels) < NUM_CH) ? int'(model_cfg.active_channels)
                                                         : NUM_CH;
      if (live == 0 || $urandom_range(0, 99) < 15)
         return $urandom_range(0, 255);
      return $urandom_range(0, live - 1);
   endfunction

   function automatic int pick_period();
      case ($urandom_range(0, 9))
         0:       return 0;
         1, 2, 3: return $urandom_range(1, 300);
         4, 5:    return $urandom_range(300, 20000);
         6:       return 65535;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // mostly complete pulses (rise, some overflows, fall, read) with random content,
   // mixed with stray reads, overflows, edges and unused ops
   task automatic plan_traffic(input int n);
      int start;
      int ch;
      int r;
      int f;
      int w;
      int k;
      int period;
      int mw;
      start = planned_words;
      while (planned_words - start < n) begin
         case ($urandom_range(0, 99)) inside
            [0:59]: begin
               ch     = aim_channel();
               r      = $urandom_range(0, 65535);
               k      = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
               period = pick_period();
               mw     = int'(model_cfg.max_width);
               w      = $urandom_range(0, mw + mw / 8 + 2);
               push_word(OP_EDGE, ch, r);
               for (int i = 0; i < k; i++)
                  push_word(OP_OVERFLOW, ch, period);
               // aim the fall so the width lands near the window, now and then anywhere
               if (k == 0 || $urandom_range(0, 1) == 0)
                  f = r + w - k * int'(model_cfg.timer_reload);
               else
                  f = $urandom_range(0, 65535);
               push_word(OP_EDGE, ch, f & 16'hffff);
               if ($urandom_range(0, 9) < 7)
                  push_word(OP_READ, ch, $urandom_range(0, 65535));
            end
            [60:74]: push_word(OP_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 9),
                               $urandom_range(0, 65535));
            [75:84]: push_word(OP_OVERFLOW, aim_channel(), pick_period());
            [85:92]: push_word(OP_EDGE, $urandom_range(0, 255), $urandom_range(0, 65535));
            default: push_word(($urandom_range(0, 1) == 0) ? OP_UNUSED : 2'($urandom_range(0, 3)),
                               $urandom_range(0, 255), $urandom_range(0, 65535));
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------

   // called on a clock edge; returns on the edge that took the write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ACTIVE_CHANNELS: model_cfg.active_channels = value[3:0];
         CSR_TIMER_RELOAD:    model_cfg.timer_reload    = value[15:0];
         CSR_TIMEOUT_LIMIT:   model_cfg.timeout_limit   = value[19:0];
         CSR_MAX_WIDTH:       model_cfg.max_width       = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input cfg_type s);
      write_csr(CSR_ACTIVE_CHANNELS, CSR_DATA_W'(s.active_channels));
      write_csr(CSR_TIMER_RELOAD, CSR_DATA_W'(s.timer_reload));
      write_csr(CSR_TIMEOUT_LIMIT, CSR_DATA_W'(s.timeout_limit));
      write_csr(CSR_MAX_WIDTH, CSR_DATA_W'(s.max_width));
      csr_valid <= 1'b0;
   endtask

   // wait for every queued word to go in and every read to come back,
   // then let edge and overflow words still inside the pipe settle
   task automatic drain();
      while (words_to_send.size() != 0 || word_offered || widths_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // request driver: bursts of random length, random gaps in between
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : sender
      req_type nxt;
      logic    offer;
      if (reset) begin
         req_valid    <= 1'b0;
         word_offered  = 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            apply_word(req_data);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0 && !squeeze) begin
               gap_left--;
            end else if (words_to_send.size() != 0) begin
               gap_left = 0;
               nxt      = words_to_send.pop_front();
               req_data <= nxt;
               offer    = 1'b1;
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 24);
               burst_left--;
               if (burst_left == 0) begin
                  // some bursts run straight into the next one
                  case ($urandom_range(0, 19)) inside
                     [0:4]:   gap_left = 0;
                     [5:16]:  gap_left = $urandom_range(1, 4);
                     default: gap_left = $urandom_range(5, 30);
                  endcase
               end
            end
         end
         // payload only changes with a fresh word; valid gets exactly one update here
         req_valid    <= offer;
         word_offered  = offer;
      end
   end

   // ---------------------------------------------------------------------
   // response stall pattern, with a one-time long hold-off when squeezed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (squeeze && !squeeze_seen) begin
            hold_left    = HOLD_OFF_CYCLES;
            squeeze_seen = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  stall_next = 1'b0;
            STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: stall_next = ($urandom_range(0, 4) != 0);
            default:     stall_next = ~rsp_stall;
         endcase
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end
         rsp_stall <= stall_next;
      end
   end

   // ---------------------------------------------------------------------
   // response monitor: oldest expected read against each taken response word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (widths_due.size() == 0) begin
            $error("unexpected response word: status %0d width %0d",
                   rsp_data.status, rsp_data.width);
            mismatches++;
         end else begin
            due = widths_due.pop_front();
            reads_checked++;
            if (rsp_data.status !== due.status) begin
               $error("status mismatch: expected %0d, actual %0d", due.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.width !== due.width) begin
               $error("width mismatch: expected %0d, actual %0d", due.width, rsp_data.width);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long with no handshake on any port means the block hung
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("no handshake for %0d cycles", idle_cycles);
         $display("tb_pwm_pulse_width_capture_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : sequencer
      cfg_type s;
      clear_capture_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed pass at reset settings
      push_word(OP_READ, 0, 0);                  // channel starts in timeout
      push_word(OP_READ, 255, 16'hffff);         // far out of range
      push_word(OP_READ, NUM_CH, 0);             // first channel past the hardware
      push_word(OP_EDGE, 0, 100);                // plain pulse of 1000 ticks
      push_word(OP_EDGE, 0, 1100);
      push_word(OP_READ, 0, 0);
      push_word(OP_EDGE, 1, 16'hffff);           // one overflow and a fall below the rise:
      push_word(OP_OVERFLOW, 1, 1000);           // no reload added, width goes negative
      push_word(OP_EDGE, 1, 2000);
      push_word(OP_READ, 1, 0);
      push_word(OP_EDGE, 2, 0);                  // width exactly at the upper limit
      push_word(OP_EDGE, 2, MAX_WIDTH_RESET);
      push_word(OP_READ, 2, 0);
      push_word(OP_EDGE, 3, 0);                  // one tick above the limit, dropped
      push_word(OP_EDGE, 3, MAX_WIDTH_RESET + 1);
      push_word(OP_READ, 3, 0);
      push_word(OP_OVERFLOW, 2, 16'hffff);       // two long periods force a timeout
      push_word(OP_OVERFLOW, 2, 16'hffff);
      push_word(OP_READ, 2, 0);
      push_word(OP_EDGE, 9, 500);                // edge beyond the hardware, ignored
      push_word(OP_UNUSED, 0, 16'hffff);         // unused op, ignored
      push_word(OP_EDGE, 4, 16'hffff);           // zero width at the top of the count
      push_word(OP_EDGE, 4, 16'hffff);
      push_word(OP_READ, 4, 0);
      push_word(OP_READ, 0, 0);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: s = '{4'd8, 16'd65535, 20'd100000, 16'd3000};   // reset values, written
            1: s = '{4'd1, 16'd1, 20'd1, 16'd0};               // one channel, tightest limits
            2: s = '{4'd15, 16'd0, 20'd0, 16'd65535};          // no reload, instant timeout
            3: s = '{4'd4, 16'd1000, 20'd1048575, 16'd65535};  // timeout out of reach
            4: s = '{4'd0, 16'd500, 20'd2000, 16'd100};        // no channel wired
            5: s = '{4'd8, 16'd100, 20'd20000, 16'd2500};      // small reload, wraps often
            6: s = '{4'd6, 16'd20000, 20'd1048575, 16'd65535};
            7: s = '{4'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)),
                     20'($urandom_range(1, 1048575)), 16'($urandom_range(0, 65535))};
            default: s = '{4'd8, 16'd300, 20'd50000, 16'd4000};
         endcase
         write_settings(s);
         plan_traffic(PHASE_WORDS);
         // last phase: the receiver holds off long while the sender keeps pushing
         if (p == NUM_PHASES - 1)
            squeeze = 1'b1;
         drain();
         squeeze = 1'b0;
      end

      $display("run covered %0d edge, %0d overflow and %0d checked read words",
               edges_seen, overflows_seen, reads_checked);
      $display("over %0d register settings, including zero and full-range register values",
               NUM_PHASES + 1);
      if (mismatches == 0 && widths_due.size() == 0)
         $display("tb_pwm_pulse_width_capture_top: PASS");
      else
         $display("tb_pwm_pulse_width_capture_top: FAIL");
      $finish;
   end

endmodule

### sim.f
src/pwc_pkg.sv
src/pwc_core.sv
src/pwm_pulse_width_capture_top.sv
verif/tb_pwm_pulse_width_capture_top.sv
